// File: rtl/core/aqpu_pkg.sv
package aqpu_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_RND,
		ST_ACC,
		ST_ROOT_GO,
		ST_ROOT,
		ST_DIV_GO,
		ST_DIV,
		ST_OUT
	} aqpu_state_t;

	typedef enum logic [1:0] {
		SH_30,
		SH_32,
		SH_19
	} aqpu_shift_t;

	typedef enum logic {
		RD_SQRT,
		RD_DIV
	} aqpu_rd_mode_t;

	typedef struct packed {
		logic        issue;
		logic        neg;
		aqpu_shift_t shift;
	} aqpu_mul_ctl_t;

	typedef struct packed {
		logic          start;
		aqpu_rd_mode_t mode;
	} aqpu_rd_ctl_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} aqpu_rd_stat_t;

	// one term of the quaternion product: component, q index, h index, sign, first/last
	typedef struct packed {
		logic [1:0] comp;
		logic [1:0] qi;
		logic [1:0] hi;
		logic       sub;
		logic       first;
		logic       last;
	} aqpu_qterm_t;

	localparam logic [1:0] REG_PROP   = 2'd0;
	localparam logic [1:0] REG_INTEG  = 2'd1;
	localparam logic [1:0] REG_PERIOD = 2'd2;

	localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

	function automatic aqpu_qterm_t qterm(input logic [3:0] j);
		aqpu_qterm_t t;
		t = '0;
		unique case (j)
			4'd0:  t = '{comp: 2'd0, qi: 2'd1, hi: 2'd0, sub: 1'b1, first: 1'b1, last: 1'b0};
			4'd1:  t = '{comp: 2'd0, qi: 2'd2, hi: 2'd1, sub: 1'b1, first: 1'b0, last: 1'b0};
			4'd2:  t = '{comp: 2'd0, qi: 2'd3, hi: 2'd2, sub: 1'b1, first: 1'b0, last: 1'b1};
			4'd3:  t = '{comp: 2'd1, qi: 2'd0, hi: 2'd0, sub: 1'b0, first: 1'b1, last: 1'b0};
			4'd4:  t = '{comp: 2'd1, qi: 2'd2, hi: 2'd2, sub: 1'b0, first: 1'b0, last: 1'b0};
			4'd5:  t = '{comp: 2'd1, qi: 2'd3, hi: 2'd1, sub: 1'b1, first: 1'b0, last: 1'b1};
			4'd6:  t = '{comp: 2'd2, qi: 2'd0, hi: 2'd1, sub: 1'b0, first: 1'b1, last: 1'b0};
			4'd7:  t = '{comp: 2'd2, qi: 2'd1, hi: 2'd2, sub: 1'b1, first: 1'b0, last: 1'b0};
			4'd8:  t = '{comp: 2'd2, qi: 2'd3, hi: 2'd0, sub: 1'b0, first: 1'b0, last: 1'b1};
			4'd9:  t = '{comp: 2'd3, qi: 2'd0, hi: 2'd2, sub: 1'b0, first: 1'b1, last: 1'b0};
			4'd10: t = '{comp: 2'd3, qi: 2'd1, hi: 2'd1, sub: 1'b0, first: 1'b0, last: 1'b0};
			4'd11: t = '{comp: 2'd3, qi: 2'd2, hi: 2'd0, sub: 1'b1, first: 1'b0, last: 1'b1};
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

// File: rtl/core/aqpu_mul.sv
module aqpu_mul (
	input  logic                    clk,
	input  aqpu_pkg::aqpu_mul_ctl_t ctl,
	input  logic [31:0]             a_mag,
	input  logic [31:0]             b_mag,
	output logic [63:0]             prod,
	output logic signed [47:0]      res
);
	import aqpu_pkg::*;

	logic [63:0]        prod_s1;
	logic               neg_s1;
	aqpu_shift_t        sh_s1;
	logic signed [47:0] res_s2;
	logic [64:0]        rsum;
	logic [45:0]        rmag;

	always_ff @(posedge clk) begin
		if (ctl.issue) begin
			prod_s1 <= 64'(a_mag) * 64'(b_mag);
			neg_s1  <= ctl.neg;
			sh_s1   <= ctl.shift;
		end
	end

	// round to nearest, ties away from zero, on the magnitude
	always_comb begin
		rsum = '0;
		rmag = '0;
		unique case (sh_s1)
			SH_30: begin
				rsum = {1'b0, prod_s1} + 65'h0_2000_0000;
				rmag = 46'(rsum >> 30);
			end
			SH_32: begin
				rsum = {1'b0, prod_s1} + 65'h0_8000_0000;
				rmag = 46'(rsum >> 32);
			end
			SH_19: begin
				rsum = {1'b0, prod_s1} + 65'h0_0004_0000;
				rmag = 46'(rsum >> 19);
			end
			default: begin
				rsum = {1'b0, prod_s1};
				rmag = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		res_s2 <= neg_s1 ? -$signed({2'b00, rmag}) : $signed({2'b00, rmag});
	end

	assign prod = prod_s1;
	assign res  = res_s2;
endmodule

// File: rtl/core/aqpu_rootdiv.sv
module aqpu_rootdiv (
	input  logic                    clk,
	input  logic                    arst_n,
	input  aqpu_pkg::aqpu_rd_ctl_t  ctl,
	input  logic [63:0]             rad,
	input  logic [31:0]             num_mag,
	input  logic [31:0]             den,
	output aqpu_pkg::aqpu_rd_stat_t stat,
	output logic [31:0]             root,
	output logic [31:0]             quot
);
	import aqpu_pkg::*;

	logic          busy_q;
	logic          done_q;
	logic [4:0]    cnt_q;
	aqpu_rd_mode_t mode_q;
	logic [63:0]   v_q;
	logic [63:0]   res_q;
	logic [63:0]   bit_q;
	logic [31:0]   rem_q;
	logic [31:0]   dlo_q;
	logic [31:0]   quo_q;
	logic          ovf_q;

	logic [63:0] sq_try;
	logic        sq_ge;
	logic [63:0] dvd;
	logic        dv_ovf;
	logic [32:0] dv_sh;
	logic        dv_ge;
	logic [32:0] dv_diff;
	logic        last;

	assign last    = (cnt_q == 5'd31);
	assign sq_try  = res_q + bit_q;
	assign sq_ge   = (v_q >= sq_try);
	// (|n| << 29) + nm/2; quotient must stay below 2^32 or ovf is set
	assign dvd     = {3'b000, num_mag, 29'b0} + {33'b0, den[31:1]};
	assign dv_ovf  = (dvd >= {den, 32'b0});
	assign dv_sh   = {rem_q, dlo_q[31]};
	assign dv_ge   = (dv_sh >= {1'b0, den});
	assign dv_diff = dv_sh - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (last)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mode_q <= ctl.mode;
			if (ctl.mode == RD_SQRT) begin
				v_q   <= rad;
				res_q <= '0;
				bit_q <= 64'h4000_0000_0000_0000;
			end else begin
				rem_q <= dvd[63:32];
				dlo_q <= dvd[31:0];
				quo_q <= '0;
				ovf_q <= dv_ovf;
			end
		end else if (busy_q) begin
			if (mode_q == RD_SQRT) begin
				if (sq_ge) begin
					v_q   <= v_q - sq_try;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end else begin
				if (dv_ge)
					rem_q <= dv_diff[31:0];
				else
					rem_q <= dv_sh[31:0];
				dlo_q <= {dlo_q[30:0], 1'b0};
				quo_q <= {quo_q[30:0], dv_ge};
			end
		end
	end

	assign root      = res_q[31:0];
	assign quot      = quo_q;
	assign stat.done = done_q;
	assign stat.ovf  = ovf_q;
endmodule

// File: rtl/core/ahrs_quaternion_pi_update_core.sv
// Reinitialise or zero-error transaction: result valid the cycle after acceptance.
// Update transaction: its length is set by one shared 32x32 multiplier (28 products, or 22
// with integral gain zero) and a bit-serial root/divide unit (one root, then four divides
// unless the root is zero).
// One transaction at a time; input stalls until the result has been taken.
// Reset (arst_n low): unit quaternion, zero integral, gain and period registers to defaults.
module ahrs_quaternion_pi_update_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic signed [31:0] gyro_x,
	input  logic signed [31:0] gyro_y,
	input  logic signed [31:0] gyro_z,
	input  logic signed [31:0] err_x,
	input  logic signed [31:0] err_y,
	input  logic signed [31:0] err_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] quat_w,
	output logic signed [31:0] quat_x,
	output logic signed [31:0] quat_y,
	output logic signed [31:0] quat_z,
	output logic               updated
);
	import aqpu_pkg::*;

	localparam logic [4:0] OP_QUAT = 5'd12;
	localparam logic [4:0] OP_SQ   = 5'd24;
	localparam logic [4:0] OP_LAST = 5'd27;

	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		if (v > 48'sd2147483647)
			return 32'sh7fff_ffff;
		else if (v < -48'sd2147483648)
			return 32'sh8000_0000;
		else
			return v[31:0];
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	aqpu_state_t state_q, state_d;

	logic [30:0] prop_q;
	logic [30:0] integ_gain_q;
	logic [31:0] period_q;

	logic signed [31:0] att_q   [4];
	logic signed [31:0] integ_q [3];
	logic signed [31:0] g_q     [3];
	logic signed [31:0] e_q     [3];
	logic signed [31:0] h_q     [3];
	logic signed [31:0] nq_q    [4];
	logic [31:0]        a_mag_q;
	logic               a_neg_q;
	logic signed [35:0] acc_q;
	logic [63:0]        s_q;
	logic [31:0]        nm_q;
	logic [4:0]         op_q;
	logic [1:0]         comp_q;
	logic               upd_q;

	aqpu_mul_ctl_t      mul_ctl;
	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [63:0]        mul_prod;
	logic signed [47:0] mul_res;

	aqpu_rd_ctl_t  rd_ctl;
	aqpu_rd_stat_t rd_stat;
	logic [31:0]   rd_root;
	logic [31:0]   rd_quot;

	logic               ki_on;
	logic               e_zero;
	logic               cfg_wr;
	logic [1:0]         axis;
	logic [1:0]         step;
	aqpu_qterm_t        qt;
	logic [4:0]         op_inc;
	logic [4:0]         op_next;
	logic signed [35:0] qsum;
	logic               div_neg;
	logic signed [31:0] div_val;

	assign ki_on  = (integ_gain_q != '0);
	assign e_zero = (err_x == '0) && (err_y == '0) && (err_z == '0);
	assign cfg_wr = psel && penable && pwrite && pready;
	assign axis   = op_q[3:2];
	assign step   = op_q[1:0];
	assign qt     = qterm(4'(op_q - OP_QUAT));
	assign op_inc = op_q + 5'd1;
	// integral products are skipped when the integral gain is zero
	assign op_next = (op_inc < OP_QUAT && op_inc[1:0] == 2'd0 && !ki_on) ?
		5'(op_inc + 5'd2) : op_inc;
	assign qsum = (qt.first ? 36'(att_q[qt.comp]) : acc_q) + 36'(mul_res);

	assign div_neg = nq_q[comp_q][31];
	always_comb begin
		if (rd_stat.ovf || rd_quot[31])
			div_val = div_neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
		else
			div_val = div_neg ? -$signed(rd_quot) : $signed(rd_quot);
	end

	// configuration
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_q       <= 31'd65536;
			integ_gain_q <= '0;
			period_q     <= 32'd12098499;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_PROP:   prop_q       <= pwdata[30:0];
				REG_INTEG:  integ_gain_q <= pwdata[30:0];
				REG_PERIOD: period_q     <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_PROP:   prdata = {1'b0, prop_q};
			REG_INTEG:  prdata = {1'b0, integ_gain_q};
			REG_PERIOD: prdata = period_q;
			default:    prdata = '0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:
				if (in_valid)
					state_d = (action || e_zero) ? ST_OUT : ST_MUL;
			ST_MUL:     state_d = ST_RND;
			ST_RND:     state_d = ST_ACC;
			ST_ACC:     state_d = (op_q == OP_LAST) ? ST_ROOT_GO : ST_MUL;
			ST_ROOT_GO: state_d = ST_ROOT;
			ST_ROOT:
				if (rd_stat.done)
					state_d = (rd_root == '0) ? ST_OUT : ST_DIV_GO;
			ST_DIV_GO:  state_d = ST_DIV;
			ST_DIV:
				if (rd_stat.done)
					state_d = (comp_q == 2'd3) ? ST_OUT : ST_DIV_GO;
			ST_OUT:
				if (!out_stall)
					state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// outputs and operand selection
	always_comb begin
		in_stall      = (state_q != ST_IDLE);
		out_valid     = (state_q == ST_OUT);
		rd_ctl.start  = (state_q == ST_ROOT_GO) || (state_q == ST_DIV_GO);
		rd_ctl.mode   = (state_q == ST_DIV_GO) ? RD_DIV : RD_SQRT;
		mul_ctl.issue = (state_q == ST_MUL);
		mul_ctl.neg   = 1'b0;
		mul_ctl.shift = SH_30;
		mul_a         = '0;
		mul_b         = '0;
		if (op_q < OP_QUAT) begin
			unique case (step)
				2'd0: begin
					mul_a       = {1'b0, integ_gain_q};
					mul_b       = mag32(e_q[axis]);
					mul_ctl.neg = e_q[axis][31];
				end
				2'd1: begin
					mul_a         = a_mag_q;
					mul_b         = period_q;
					mul_ctl.neg   = a_neg_q;
					mul_ctl.shift = SH_32;
				end
				2'd2: begin
					mul_a       = {1'b0, prop_q};
					mul_b       = mag32(e_q[axis]);
					mul_ctl.neg = e_q[axis][31];
				end
				default: begin
					mul_a         = mag32(g_q[axis]);
					mul_b         = period_q;
					mul_ctl.neg   = g_q[axis][31];
					mul_ctl.shift = SH_19;
				end
			endcase
		end else if (op_q < OP_SQ) begin
			mul_a       = mag32(att_q[qt.qi]);
			mul_b       = mag32(h_q[qt.hi]);
			mul_ctl.neg = att_q[qt.qi][31] ^ h_q[qt.hi][31] ^ qt.sub;
		end else begin
			mul_a = mag32(nq_q[op_q[1:0]]);
			mul_b = mag32(nq_q[op_q[1:0]]);
		end
	end

	// state with reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			att_q   <= '{Q30_ONE, 32'sd0, 32'sd0, 32'sd0};
			integ_q <= '{32'sd0, 32'sd0, 32'sd0};
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE:
					if (in_valid && action) begin
						att_q   <= '{Q30_ONE, 32'sd0, 32'sd0, 32'sd0};
						integ_q <= '{32'sd0, 32'sd0, 32'sd0};
					end
				ST_ACC:
					if (op_q < OP_QUAT && step == 2'd1)
						integ_q[axis] <= sat32(48'(integ_q[axis]) + mul_res);
				ST_ROOT:
					if (rd_stat.done && rd_root == '0)
						att_q <= '{Q30_ONE, 32'sd0, 32'sd0, 32'sd0};
				ST_DIV:
					if (rd_stat.done)
						att_q[comp_q] <= div_val;
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE:
				if (in_valid) begin
					upd_q <= !action && !e_zero;
					g_q   <= '{gyro_x, gyro_y, gyro_z};
					e_q   <= '{err_x, err_y, err_z};
					op_q  <= ki_on ? 5'd0 : 5'd2;
				end
			ST_MUL:
				if (op_q < OP_QUAT && step == 2'd2 && ki_on)
					g_q[axis] <= sat32(48'(g_q[axis]) + 48'(integ_q[axis]));
			ST_ACC: begin
				op_q <= op_next;
				if (op_q < OP_QUAT) begin
					unique case (step)
						2'd0: begin
							a_neg_q <= mul_res[47];
							a_mag_q <= 32'(mul_res[47] ? -mul_res : mul_res);
						end
						2'd1: ;
						2'd2: g_q[axis] <= sat32(48'(g_q[axis]) + mul_res);
						default: h_q[axis] <= sat32(mul_res);
					endcase
				end else if (op_q < OP_SQ) begin
					if (qt.last)
						nq_q[qt.comp] <= sat32(48'(qsum));
					else
						acc_q <= qsum;
				end else begin
					s_q <= ((op_q[1:0] == 2'd0) ? 64'd0 : s_q) + (mul_prod >> 2);
				end
			end
			ST_ROOT:
				if (rd_stat.done) begin
					nm_q   <= rd_root;
					comp_q <= 2'd0;
				end
			ST_DIV:
				if (rd_stat.done)
					comp_q <= comp_q + 2'd1;
			default: ;
		endcase
	end

	aqpu_mul u_mul (
		.clk   (clk),
		.ctl   (mul_ctl),
		.a_mag (mul_a),
		.b_mag (mul_b),
		.prod  (mul_prod),
		.res   (mul_res)
	);

	aqpu_rootdiv u_rootdiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (rd_ctl),
		.rad     (s_q),
		.num_mag (mag32(nq_q[comp_q])),
		.den     (nm_q),
		.stat    (rd_stat),
		.root    (rd_root),
		.quot    (rd_quot)
	);

	assign quat_w  = att_q[0];
	assign quat_x  = att_q[1];
	assign quat_y  = att_q[2];
	assign quat_z  = att_q[3];
	assign updated = upd_q;
endmodule

// File: rtl/core/aqpu_checker.sv
module aqpu_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] quat_w,
	input logic signed [31:0] quat_x,
	input logic signed [31:0] quat_y,
	input logic signed [31:0] quat_z,
	input logic               updated
);
	// an accepted transaction keeps the input side busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while previous transaction in flight");

	// no new transaction while a result is pending
	a_stall_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");

	// exactly one result per transaction
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid)
		else $error("result repeated");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(quat_w) && $stable(quat_x)
			&& $stable(quat_y) && $stable(quat_z) && $stable(updated))
		else $error("stalled result changed");
endmodule

bind ahrs_quaternion_pi_update_core aqpu_checker u_aqpu_checker (.*);

// File: test/aqpu_checker.sv
`timescale 1ns / 100ps

module aqpu_scoreboard (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               action,
	input  logic signed [31:0] gyro_x,
	input  logic signed [31:0] gyro_y,
	input  logic signed [31:0] gyro_z,
	input  logic signed [31:0] err_x,
	input  logic signed [31:0] err_y,
	input  logic signed [31:0] err_z,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] quat_w,
	input  logic signed [31:0] quat_x,
	input  logic signed [31:0] quat_y,
	input  logic signed [31:0] quat_z,
	input  logic               updated,
	output int                 fails,
	output int                 pending
);
	import aqpu_pkg::*;

	typedef struct {
		logic signed [31:0] w, x, y, z;
		logic               upd;
	} attitude_t;

	attitude_t   attitude_q[$];
	logic [30:0] kp2, ki2;
	logic [31:0] period;
	longint      att[4];
	longint      integ[3];

	function automatic logic [63:0] mag(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// exact magnitude product, rounded half away from zero at the shift
	function automatic longint mul_round(longint a, longint b, int sh);
		logic [127:0] m;
		logic         neg;
		m = 128'(mag(a)) * 128'(mag(b));
		neg = (a < 0) != (b < 0);
		if (sh > 0)
			m = (m + (128'(1) << (sh - 1))) >> sh;
		return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
	endfunction

	function automatic logic [63:0] root64(logic [63:0] v);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	task automatic unit_attitude();
		att[0] = 64'sd1073741824;
		att[1] = 0; att[2] = 0; att[3] = 0;
	endtask

	task automatic step_attitude(input logic act, input longint gin[3], input longint ein[3]);
		longint    g[3], h[3], q[4], n[4];
		longint    t, a;
		logic [63:0] s, nm, m;
		attitude_t r;
		r.upd = 0;
		t = longint'(period);
		if (act) begin
			unit_attitude();
			integ[0] = 0; integ[1] = 0; integ[2] = 0;
		end else if (ein[0] != 0 || ein[1] != 0 || ein[2] != 0) begin
			r.upd = 1;
			for (int i = 0; i < 3; i++) begin
				g[i] = gin[i];
				if (ki2 != 0) begin
					a = mul_round(longint'(ki2), ein[i], 30);
					integ[i] = sat32(integ[i] + mul_round(a, t, 32));
					g[i] = sat32(g[i] + integ[i]);
				end
				g[i] = sat32(g[i] + mul_round(longint'(kp2), ein[i], 30));
				h[i] = sat32(mul_round(g[i], t, 19));
			end
			for (int i = 0; i < 4; i++) q[i] = att[i];
			n[0] = sat32(q[0] - mul_round(q[1], h[0], 30) - mul_round(q[2], h[1], 30)
				- mul_round(q[3], h[2], 30));
			n[1] = sat32(q[1] + mul_round(q[0], h[0], 30) + mul_round(q[2], h[2], 30)
				- mul_round(q[3], h[1], 30));
			n[2] = sat32(q[2] + mul_round(q[0], h[1], 30) - mul_round(q[1], h[2], 30)
				+ mul_round(q[3], h[0], 30));
			n[3] = sat32(q[3] + mul_round(q[0], h[2], 30) + mul_round(q[1], h[1], 30)
				- mul_round(q[2], h[0], 30));
			s = 0;
			for (int i = 0; i < 4; i++) s += (mag(n[i]) * mag(n[i])) >> 2;
			nm = root64(s);
			if (nm == 0) begin
				unit_attitude();
			end else begin
				for (int i = 0; i < 4; i++) begin
					m = ((mag(n[i]) << 29) + (nm >> 1)) / nm;
					att[i] = sat32(n[i] < 0 ? -longint'(m) : longint'(m));
				end
			end
		end
		r.w = att[0][31:0]; r.x = att[1][31:0]; r.y = att[2][31:0]; r.z = att[3][31:0];
		attitude_q.push_back(r);
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
		fails++;
	endtask

	assign pending = attitude_q.size();

	initial fails = 0;

	always @(posedge clk or negedge arst_n) begin
		longint    gin[3], ein[3];
		attitude_t e;
		if (!arst_n) begin
			kp2 = 31'd65536;
			ki2 = 0;
			period = 32'd12098499;
			unit_attitude();
			integ[0] = 0; integ[1] = 0; integ[2] = 0;
			attitude_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_PROP:   kp2 = pwdata[30:0];
					REG_INTEG:  ki2 = pwdata[30:0];
					REG_PERIOD: period = pwdata;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (attitude_q.size() == 0) begin
					$display("%0t unexpected transaction on output", $realtime);
					fails++;
				end else begin
					e = attitude_q.pop_front();
					if (quat_w !== e.w) report("quat_w", quat_w, e.w);
					if (quat_x !== e.x) report("quat_x", quat_x, e.x);
					if (quat_y !== e.y) report("quat_y", quat_y, e.y);
					if (quat_z !== e.z) report("quat_z", quat_z, e.z);
					if (updated !== e.upd) report("updated", updated, e.upd);
				end
			end
			if (in_valid && !in_stall) begin
				gin[0] = gyro_x; gin[1] = gyro_y; gin[2] = gyro_z;
				ein[0] = err_x; ein[1] = err_y; ein[2] = err_z;
				step_attitude(action, gin, ein);
			end
		end
	end

endmodule

// File: test/ahrs_quaternion_pi_update_core_tb.sv
`timescale 1ns / 100ps

module ahrs_quaternion_pi_update_core_tb;
	import aqpu_pkg::*;

	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int LONG_HOLD   = 2000;

	logic               clk, arst_n;
	logic               psel, penable, pwrite, pready;
	logic [3:0]         paddr;
	logic [31:0]        pwdata, prdata;
	logic               in_valid, in_stall, out_valid, out_stall;
	logic               action, updated;
	logic signed [31:0] gyro_x, gyro_y, gyro_z, err_x, err_y, err_z;
	logic signed [31:0] quat_w, quat_x, quat_y, quat_z;
	int                 fails, pending, cycles;
	bit                 quiet, hold_req;

	ahrs_quaternion_pi_update_core dut (.*);

	aqpu_scoreboard u_scoreboard (.*);

	initial clk = 0;
	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// receiver: random stall bursts, or one long hold-off on request
	initial begin
		out_stall <= 1'b0;
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic send(input logic act, input logic [31:0] gx, gy, gz, ex, ey, ez);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1;
		action <= act;
		gyro_x <= gx; gyro_y <= gy; gyro_z <= gz;
		err_x <= ex; err_y <= ey; err_z <= ez;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] rate_val();
		return $urandom_range(0, 3) == 0 ? $urandom
			: 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
	endfunction

	function automatic logic [31:0] err_val();
		return $urandom_range(0, 3) == 0 ? $urandom
			: 32'($signed($urandom_range(0, 1 << 27)) - (1 << 26));
	endfunction

	task automatic random_item();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 4)
			send(1, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		else if (sel < 12)
			send(0, $urandom, $urandom, $urandom, 0, 0, 0);
		else if (sel < 22)
			send(0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		else
			send(0, rate_val(), rate_val(), rate_val(), err_val(), err_val(), err_val());
	endtask

	task automatic set_gains(input logic [31:0] kp, ki, per);
		reg_write(REG_PROP, kp);
		reg_write(REG_INTEG, ki);
		reg_write(REG_PERIOD, per);
	endtask

	initial begin
		logic [31:0] kp_set[8], ki_set[8], per_set[8];
		quiet = 0; hold_req = 0;
		arst_n <= 0;
		psel <= 0; penable <= 0; pwrite <= 0; paddr <= 0; pwdata <= 0;
		in_valid <= 0; action <= 0;
		gyro_x <= 0; gyro_y <= 0; gyro_z <= 0; err_x <= 0; err_y <= 0; err_z <= 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset settings first
		send(0, 32'sh0001_0000, 0, 0, 0, 0, 0);
		send(0, 32'sh0001_0000, 32'sh0000_8000, -32'sh0002_0000, 32'sh0100_0000, 0, 0);
		send(0, 0, 0, 0, 0, 32'sh0010_0000, 0);
		send(0, 0, 0, 0, 0, 0, -32'sh0008_0000);
		send(0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		send(0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
		send(0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		send(0, 0, 0, 0, 0, 0, 0);
		send(1, 32'hffff_ffff, 0, 32'hffff_ffff, 32'hffff_ffff, 0, 1);
		send(0, 0, 0, 0, 1, 0, 0);
		drain();
		set_gains(32'd32768, 32'd4096, 32'd12098499);
		reg_write(2'd3, 32'hdead_beef);   // unmapped register, no effect
		send(0, 32'sh0000_4000, 0, 0, 32'sh0040_0000, -32'sh0040_0000, 32'sh0001_0000);
		send(0, 0, 32'sh0002_0000, 0, 32'sh0040_0000, 32'sh0040_0000, 0);
		send(0, 0, 0, 0, 0, 0, 0);
		send(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send(1, 0, 0, 0, 0, 0, 0);
		drain();
		// zero sample period
		set_gains(32'h7fff_ffff, 32'h7fff_ffff, 32'd0);
		send(0, 32'h7fff_ffff, 32'h8000_0000, 0, 32'h7fff_ffff, 32'h8000_0000, 1);
		send(0, 32'sh0001_0000, 0, 0, 32'sh0100_0000, 0, 0);
		drain();

		kp_set  = '{32'd65536, 0, 32'hffff_ffff, 32'd131072, 32'd65536, 32'h7fff_ffff, 32'd1,
			32'd200000};
		ki_set  = '{0, 32'h7fff_ffff, 32'hffff_ffff, 32'd8192, 32'd1, 0, 32'd65536, 32'd2000};
		per_set = '{32'd12098499, 32'd1, 32'hffff_ffff, 32'd42949673, 32'd12098499,
			32'd4294967, 32'h8000_0000, 32'd12098499};
		for (int ph = 0; ph < 8; ph++) begin
			set_gains(kp_set[ph], ki_set[ph], per_set[ph]);
			if (ph == 7) quiet = 1;
			for (int k = 0; k < 200; k++) begin
				if (ph == 2 && k == 50) hold_req = 1;
				if (ph == 4 && k == 100) drain();
				random_item();
			end
			drain();
		end

		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (fails == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
